// File: hw/rtl/mwr_pkg.sv
// mwr_pkg: shared constants and types for the maximum width ramp block
// no dependencies; used by the channel interfaces, the top level and its checker

package mwr_pkg;

	localparam int MaxLenDef     = 4096;
	localparam int ValueWidthDef = 32;
	localparam int RampW         = 12;
	localparam int WidthMax      = 4095;

	typedef enum logic [2:0] {
		S_LOAD,
		S_RD_POS,
		S_CMP,
		S_RD_STK,
		S_RD_TOP,
		S_GET_TOP,
		S_EMIT
	} mwr_state_t;

endpackage

// File: hw/rtl/mwr_if.sv
// mwr_in_if and mwr_out_if: valid/ready channels of the maximum width ramp block
// depends on mwr_pkg for the result width

interface mwr_in_if #(
	parameter int VALUE_WIDTH = mwr_pkg::ValueWidthDef
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] sample_value;
	logic                   is_last;

	modport source (output valid, output sample_value, output is_last, input ready);
	modport sink   (input valid, input sample_value, input is_last, output ready);
endinterface

interface mwr_out_if;
	logic                     valid;
	logic                     ready;
	logic [mwr_pkg::RampW-1:0] ramp_width;
	logic                     overflowed;

	modport source (output valid, output ramp_width, output overflowed, input ready);
	modport sink   (input valid, input ramp_width, input overflowed, output ready);
endinterface

// File: hw/rtl/max_width_ramp.sv
// max_width_ramp: maximum width ramp of a signed sequence, monotonic stack method
// depends on mwr_pkg, mwr_if (channels) and mwr_ram (value and stack memories)

// Elements stream in on samples at one transaction per cycle while in S_LOAD;
// each is written to the value memory and, when the stack is empty or it is
// below the current stack top, its index is pushed onto the stack memory. The
// transaction with is_last closes the sequence, and samples.ready stays low
// while a backward scan runs and until the result register is free: each step
// back over an element passes through S_RD_POS and S_CMP and each pop of the
// stack through S_RD_STK, S_RD_TOP and S_GET_TOP, since every value and stack
// lookup goes through the single registered read port of the memories. The
// result sits in an output register, so loading of the next sequence starts
// while it waits on result.ready. Elements beyond MAX_LEN are dropped and flagged
// in overflowed; widths above 4095 saturate. Memories need no clearing after reset.

module max_width_ramp #(
	parameter int MAX_LEN     = mwr_pkg::MaxLenDef,
	parameter int VALUE_WIDTH = mwr_pkg::ValueWidthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	mwr_in_if.sink    samples,
	mwr_out_if.source result
);

	localparam int IdxW = $clog2(MAX_LEN);
	localparam int CntW = $clog2(MAX_LEN + 1);
	localparam int RampW = mwr_pkg::RampW;

	mwr_pkg::mwr_state_t state_q, state_d;

	logic [CntW-1:0]        count_q;
	logic [CntW-1:0]        depth_q;
	logic                   ovf_q;
	logic [IdxW-1:0]        top_idx_q;
	logic [VALUE_WIDTH-1:0] top_key_q;
	logic [IdxW-1:0]        pos_q;
	logic [IdxW-1:0]        best_q;
	logic                   out_valid_q;
	logic [RampW-1:0]       out_width_q;
	logic                   out_ovf_q;

	logic [VALUE_WIDTH-1:0] key;
	logic                   accept;
	logic                   full;
	logic                   push;
	logic                   in_ready;
	logic                   emit;
	logic                   pos_less;
	logic [IdxW-1:0]        diff;
	logic [RampW-1:0]       width_sat;

	logic                   v_we;
	logic [IdxW-1:0]        v_raddr;
	logic [VALUE_WIDTH-1:0] v_rdata;
	logic [IdxW-1:0]        s_raddr;
	logic [IdxW-1:0]        s_rdata;

	// offset binary, so an unsigned compare orders signed values
	assign key = {~samples.sample_value[VALUE_WIDTH-1], samples.sample_value[VALUE_WIDTH-2:0]};

	assign full     = (count_q == CntW'(MAX_LEN));
	assign accept   = samples.valid && in_ready;
	assign push     = accept && !full && ((depth_q == '0) || (key < top_key_q));
	assign v_we     = accept && !full;
	assign pos_less = (v_rdata < top_key_q);
	assign diff     = pos_q - top_idx_q;
	assign s_raddr  = IdxW'(depth_q - CntW'(1));
	assign emit     = (state_q == mwr_pkg::S_EMIT) && (!out_valid_q || result.ready);
	assign width_sat = (best_q > IdxW'(mwr_pkg::WidthMax)) ? RampW'(mwr_pkg::WidthMax)
	                                                       : RampW'(best_q);

	mwr_ram #(.DEPTH(MAX_LEN), .WIDTH(VALUE_WIDTH)) u_value_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (count_q[IdxW-1:0]),
		.wdata (key),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	mwr_ram #(.DEPTH(MAX_LEN), .WIDTH(IdxW)) u_stack_ram (
		.clk   (clk),
		.we    (push),
		.waddr (depth_q[IdxW-1:0]),
		.wdata (count_q[IdxW-1:0]),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mwr_pkg::S_LOAD: begin
				if (accept && samples.is_last) begin
					state_d = mwr_pkg::S_RD_POS;
				end
			end
			mwr_pkg::S_RD_POS: begin
				state_d = mwr_pkg::S_CMP;
			end
			mwr_pkg::S_CMP: begin
				if (pos_less) begin
					state_d = mwr_pkg::S_RD_POS;
				end else if (depth_q == CntW'(1)) begin
					state_d = mwr_pkg::S_EMIT;
				end else begin
					state_d = mwr_pkg::S_RD_STK;
				end
			end
			mwr_pkg::S_RD_STK: begin
				state_d = mwr_pkg::S_RD_TOP;
			end
			mwr_pkg::S_RD_TOP: begin
				state_d = mwr_pkg::S_GET_TOP;
			end
			mwr_pkg::S_GET_TOP: begin
				if (pos_q < top_idx_q) begin
					state_d = mwr_pkg::S_EMIT;
				end else begin
					state_d = mwr_pkg::S_RD_POS;
				end
			end
			mwr_pkg::S_EMIT: begin
				if (emit) begin
					state_d = mwr_pkg::S_LOAD;
				end
			end
			default: begin
				state_d = mwr_pkg::S_LOAD;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		in_ready = 1'b0;
		v_raddr  = pos_q;
		unique case (state_q)
			mwr_pkg::S_LOAD: begin
				in_ready = 1'b1;
			end
			mwr_pkg::S_RD_TOP: begin
				v_raddr = s_rdata;
			end
			default: begin
				v_raddr = pos_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mwr_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			depth_q   <= '0;
			ovf_q     <= 1'b0;
			top_idx_q <= '0;
			top_key_q <= '0;
			pos_q     <= '0;
			best_q    <= '0;
		end else begin
			unique case (state_q)
				mwr_pkg::S_LOAD: begin
					if (accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CntW'(1);
						end
						if (push) begin
							depth_q   <= depth_q + CntW'(1);
							top_idx_q <= count_q[IdxW-1:0];
							top_key_q <= key;
						end
						if (samples.is_last) begin
							pos_q  <= full ? IdxW'(count_q - CntW'(1)) : count_q[IdxW-1:0];
							best_q <= '0;
						end
					end
				end
				mwr_pkg::S_CMP: begin
					if (pos_less) begin
						pos_q <= pos_q - IdxW'(1);
					end else begin
						if (diff > best_q) begin
							best_q <= diff;
						end
						depth_q <= depth_q - CntW'(1);
					end
				end
				mwr_pkg::S_RD_TOP: begin
					top_idx_q <= s_rdata;
				end
				mwr_pkg::S_GET_TOP: begin
					top_key_q <= v_rdata;
				end
				mwr_pkg::S_EMIT: begin
					if (emit) begin
						count_q <= '0;
						depth_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_width_q <= width_sat;
			out_ovf_q   <= ovf_q;
		end
	end

	assign samples.ready     = in_ready;
	assign result.valid      = out_valid_q;
	assign result.ramp_width = out_width_q;
	assign result.overflowed = out_ovf_q;

endmodule

// File: hw/rtl/mwr_ram.sv
// mwr_ram: simple dual-port synchronous memory, one write and one registered read port
// depends on mwr_pkg for the default depth and width

module mwr_ram #(
	parameter int DEPTH = mwr_pkg::MaxLenDef,
	parameter int WIDTH = mwr_pkg::ValueWidthDef
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/mwr_checker.sv
// mwr_checker: port-level assertions for max_width_ramp, with its bind
// depends on mwr_pkg and the top level max_width_ramp

module mwr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      in_is_last,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [mwr_pkg::RampW-1:0] out_ramp_width,
	input logic                      out_overflowed
);

	// closing transaction starts the scan, so input stalls next cycle
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_is_last |=> !in_ready)
		else $error("input still ready after closing transaction");

	// a result never appears in the cycle right after an input transaction
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result raised directly after an input transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_ramp_width) && $stable(out_overflowed))
		else $error("result payload changed while stalled");

endmodule

bind max_width_ramp mwr_checker u_mwr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (samples.valid),
	.in_ready       (samples.ready),
	.in_is_last     (samples.is_last),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_ramp_width (result.ramp_width),
	.out_overflowed (result.overflowed)
);

// File: verif/max_width_ramp_tb.sv
`timescale 1ns / 1ps
// max_width_ramp_tb: self-checking bench for the maximum width ramp block, predicting each
// result from the accepted samples; depends on mwr_pkg, mwr_if and max_width_ramp

module max_width_ramp_tb;

	localparam int MaxLen     = mwr_pkg::MaxLenDef;
	localparam int CycleLimit = 1_500_000;
	localparam int PrintCap   = 100;

	typedef struct {
		logic [mwr_pkg::RampW-1:0] width;
		logic                      dropped;
	} ramp_result_t;

	logic clk;
	logic arst_n;

	mwr_in_if #(.VALUE_WIDTH(mwr_pkg::ValueWidthDef)) samples ();
	mwr_out_if result ();

	max_width_ramp #(
		.MAX_LEN    (MaxLen),
		.VALUE_WIDTH(mwr_pkg::ValueWidthDef)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.result (result)
	);

	// predictor state for the sequence being loaded
	logic signed [mwr_pkg::ValueWidthDef-1:0] held_vals [MaxLen];
	int                                       chain_idx [MaxLen];
	int                                       held_len;
	int                                       chain_len;
	bit                                       held_dropped;

	ramp_result_t pending_ramps [$];
	ramp_result_t got_ramp;

	int src_idle_pct;
	int sink_stall_pct;
	int mismatch_count;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PrintCap)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// backward scan over the decreasing prefix chain
	function automatic logic [mwr_pkg::RampW-1:0] widest_ramp();
		int pos;
		int top;
		int best;
		best = 0;
		pos  = held_len - 1;
		while (chain_len > 0 && held_len > 0) begin
			top = chain_idx[chain_len-1];
			if (pos < top)
				break;
			if (held_vals[pos] < held_vals[top]) begin
				pos--;
			end else begin
				if (pos - top > best)
					best = pos - top;
				chain_len--;
			end
		end
		if (best > mwr_pkg::WidthMax)
			best = mwr_pkg::WidthMax;
		return best[mwr_pkg::RampW-1:0];
	endfunction

	task automatic absorb_sample(input logic [mwr_pkg::ValueWidthDef-1:0] v, input bit last);
		ramp_result_t r;
		if (held_len < MaxLen) begin
			held_vals[held_len] = v;
			if (chain_len == 0 || $signed(v) < held_vals[chain_idx[chain_len-1]]) begin
				chain_idx[chain_len] = held_len;
				chain_len++;
			end
			held_len++;
		end else begin
			held_dropped = 1'b1;
		end
		if (last) begin
			r.width   = widest_ramp();
			r.dropped = held_dropped;
			pending_ramps.push_back(r);
			held_len     = 0;
			chain_len    = 0;
			held_dropped = 1'b0;
		end
	endtask

	task automatic send_sample(input logic [mwr_pkg::ValueWidthDef-1:0] v, input bit last);
		if ($urandom_range(99) < src_idle_pct) begin
			samples.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		samples.valid        <= 1'b1;
		samples.sample_value <= v;
		samples.is_last      <= last;
		do
			@(posedge clk);
		while (!samples.ready);
		absorb_sample(v, last);
	endtask

	task automatic send_sequence(input logic [mwr_pkg::ValueWidthDef-1:0] seq [$]);
		foreach (seq[i])
			send_sample(seq[i], i == seq.size() - 1);
	endtask

	task automatic test_directed();
		send_sequence('{32'h8000_0000});
		send_sequence('{32'h7fff_ffff});
		send_sequence('{32'd5, 32'd5});
		send_sequence('{32'h8000_0000, 32'h7fff_ffff});
		send_sequence('{32'h7fff_ffff, 32'h8000_0000});
		send_sequence('{32'd3, 32'd2, 32'd1, 32'd0});
		send_sequence('{32'd6, 32'd0, 32'd8, 32'd2, 32'd1, 32'd5});
		send_sequence('{32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff, 32'd0});
	endtask

	task automatic test_random(input int n_items, input int src_pct, input int sink_pct);
		logic [mwr_pkg::ValueWidthDef-1:0] seq [$];
		logic [mwr_pkg::ValueWidthDef-1:0] v;
		int sent;
		int len;
		int shape;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		sent = 0;
		while (sent < n_items) begin
			len   = ($urandom_range(9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
			shape = $urandom_range(3);
			v     = $urandom;
			seq.delete();
			for (int i = 0; i < len; i++) begin
				case (shape)
					0: begin
						v = $urandom_range(0, 16) - 8;
					end
					1: begin
						v = $urandom;
					end
					2: begin
						v = ($urandom_range(7) == 0) ? v + $urandom_range(0, 40)
						                             : v - $urandom_range(0, 3);
					end
					default: begin
						case ($urandom_range(3))
							0: v = 32'h8000_0000;
							1: v = 32'h7fff_ffff;
							2: v = 32'hffff_ffff;
							default: v = 32'd0;
						endcase
					end
				endcase
				seq.push_back(v);
			end
			send_sequence(seq);
			sent += len;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (pending_ramps.size() == 0) begin
					report_mismatch($sformatf("unexpected result width %0d overflowed %0b",
						result.ramp_width, result.overflowed));
				end else begin
					got_ramp = pending_ramps.pop_front();
					if (result.ramp_width !== got_ramp.width)
						report_mismatch($sformatf("ramp_width %0d, expected %0d",
							result.ramp_width, got_ramp.width));
					if (result.overflowed !== got_ramp.dropped)
						report_mismatch($sformatf("overflowed %0b, expected %0b",
							result.overflowed, got_ramp.dropped));
				end
			end
		end
		result.ready <= arst_n && ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		held_len             = 0;
		chain_len            = 0;
		held_dropped         = 1'b0;
		src_idle_pct         = 21;
		sink_stall_pct       = 59;
		arst_n               <= 1'b0;
		samples.valid        <= 1'b0;
		samples.sample_value <= '0;
		samples.is_last      <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(600, 21, 59);
		test_random(600, 59, 21);
		test_random(600, 0, 0);

		samples.valid <= 1'b0;
		while (pending_ramps.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
